// File: rtl/usp_pkg.sv
// Shared types, codes and scheme tables for the URL stream parser.
`default_nettype none

package usp_pkg;

  // Input and result beats
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_url;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic [2:0]  role;
    logic        last_of_url;
    logic [2:0]  error;
    logic        host_is_ip;
    logic [15:0] port_number;
    logic [7:0]  host_length;
    logic        default_path;
  } out_beat_t;

  // Parse phases
  localparam logic [2:0] PH_WS      = 3'd0;
  localparam logic [2:0] PH_PREFIX  = 3'd1;
  localparam logic [2:0] PH_HOST    = 3'd2;
  localparam logic [2:0] PH_PORT    = 3'd3;
  localparam logic [2:0] PH_PATH    = 3'd4;
  localparam logic [2:0] PH_QUERY   = 3'd5;
  localparam logic [2:0] PH_DISCARD = 3'd6;

  // Byte roles
  localparam logic [2:0] ROLE_SKIP    = 3'd0;
  localparam logic [2:0] ROLE_SCHEME  = 3'd1;
  localparam logic [2:0] ROLE_HOST    = 3'd2;
  localparam logic [2:0] ROLE_PORT    = 3'd3;
  localparam logic [2:0] ROLE_PATH    = 3'd4;
  localparam logic [2:0] ROLE_QUERY   = 3'd5;
  localparam logic [2:0] ROLE_DISCARD = 3'd6;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_PREFIX    = 3'd1;
  localparam logic [2:0] ERR_SCHEME    = 3'd2;
  localparam logic [2:0] ERR_PORT_CHAR = 3'd3;
  localparam logic [2:0] ERR_PORT_OVF  = 3'd4;
  localparam logic [2:0] ERR_HOST_LONG = 3'd5;

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [15:0] DEFAULT_PORT = 16'd80;
  localparam logic [8:0]  OCTET_MAX    = 9'd255;
  localparam logic [8:0]  OCTET_OVER   = 9'd256;
  localparam logic [15:0] PORT_MAX     = 16'hffff;
  localparam logic [2:0]  IP_DOTS      = 3'd3;
  localparam logic [2:0]  DOT_SAT      = 3'd4;
  localparam logic [2:0]  HOLD_MAX     = 3'd7;

  // Scheme table, index 0 is the one accepted scheme
  localparam int NUM_SCH   = 5;
  localparam int SCH_HTTP  = 0;
  localparam int SCH_HTTPS = 1;
  localparam logic [2:0] HTTP_STEM_END = 3'd3;  // position of the 'p' in "http"

  localparam logic [7:0] SCH_CHARS [NUM_SCH][8] = '{
    '{"h", "t", "t", "p", ":", "/", "/", 8'h00},
    '{"h", "t", "t", "p", "s", ":", "/", "/"},
    '{"f", "t", "p", ":", "/", "/", 8'h00, 8'h00},
    '{"f", "i", "l", "e", ":", "/", "/", 8'h00},
    '{"f", "t", "p", "s", ":", "/", "/", 8'h00}
  };
  localparam logic [3:0] SCH_LEN [NUM_SCH] = '{4'd7, 4'd8, 4'd6, 4'd7, 4'd7};

  // Parse state carried from byte to byte (host count kept apart, its width varies)
  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] port_acc;
    logic [8:0]  octet_acc;
    logic [2:0]  dot_count;
    logic        ip_valid;
    logic [2:0]  error_code;
  } body_state_t;

  localparam body_state_t BODY_RESET = '{
    phase:      PH_WS,
    port_acc:   DEFAULT_PORT,
    octet_acc:  9'd0,
    dot_count:  3'd0,
    ip_valid:   1'b1,
    error_code: ERR_NONE
  };

  // Scheme matcher verdict for the current prefix byte
  typedef struct packed {
    logic [NUM_SCH-1:0] match;
    logic               full;
    logic               full_ok;
    logic               proper;
    logic               starts_http;
  } scheme_res_t;

endpackage

`default_nettype wire

// File: rtl/usp_scheme.sv
// Scheme prefix matcher: compares the next held position against each scheme.
`default_nettype none

module usp_scheme
  import usp_pkg::*;
(
  input  logic [2:0]         held,
  input  logic [NUM_SCH-1:0] alive,
  input  logic [7:0]         char_in,
  output scheme_res_t        res
);

  logic [3:0]         m;
  logic [NUM_SCH-1:0] full_v;
  logic [NUM_SCH-1:0] proper_v;

  always_comb begin
    m = {1'b0, held} + 4'd1;
    for (int i = 0; i < NUM_SCH; i++) begin
      res.match[i] = alive[i] && (m <= SCH_LEN[i]) && (char_in == SCH_CHARS[i][held]);
      full_v[i]    = res.match[i] && (m == SCH_LEN[i]);
      proper_v[i]  = res.match[i] && (m < SCH_LEN[i]);
    end
    res.full    = |full_v;
    res.full_ok = full_v[SCH_HTTP];
    res.proper  = |proper_v;
    // four or more bytes beginning "http"
    res.starts_http = (held >= HTTP_STEM_END) && (alive[SCH_HTTP] || alive[SCH_HTTPS]) &&
                      ((held != HTTP_STEM_END) ||
                       (char_in == SCH_CHARS[SCH_HTTP][HTTP_STEM_END]));
  end

endmodule

`default_nettype wire

// File: rtl/usp_body.sv
// Per-byte host/port/path/query tagger and its next-state logic.
`default_nettype none

module usp_body
  import usp_pkg::*;
#(
  parameter int MAX_HOST = 255,
  localparam int HOST_W = $clog2(MAX_HOST + 1)
) (
  input  logic [7:0]        char_in,
  input  body_state_t       state,
  input  logic [HOST_W-1:0] host_count,
  output body_state_t       state_next,
  output logic [HOST_W-1:0] host_next,
  output logic [2:0]        role
);

  localparam logic [HOST_W-1:0] HOST_LIMIT = HOST_W'(MAX_HOST);

  logic        is_digit;
  logic [3:0]  digit;
  logic [11:0] oct_mul;
  logic [19:0] port_mul;
  logic [2:0]  dot_inc;

  always_comb begin
    is_digit = char_in inside {[CH_0:CH_9]};
    digit    = 4'(char_in - CH_0);
    oct_mul  = ({3'b0, state.octet_acc} << 3) + ({3'b0, state.octet_acc} << 1) +
               {8'b0, digit};
    port_mul = ({4'b0, state.port_acc} << 3) + ({4'b0, state.port_acc} << 1) +
               {16'b0, digit};
    dot_inc  = (state.dot_count < DOT_SAT) ? state.dot_count + 3'd1 : state.dot_count;

    state_next = state;
    host_next  = host_count;
    role       = ROLE_DISCARD;

    case (state.phase)
      PH_HOST: begin
        if (char_in == CH_COLON) begin
          state_next.phase    = PH_PORT;
          state_next.port_acc = 16'd0;
          role                = ROLE_PORT;
        end else if (char_in == CH_SLASH) begin
          state_next.phase = PH_PATH;
          role             = ROLE_PATH;
        end else if (host_count >= HOST_LIMIT) begin
          state_next.phase      = PH_DISCARD;
          state_next.error_code = ERR_HOST_LONG;
        end else begin
          host_next = host_count + HOST_W'(1);
          role      = ROLE_HOST;
          if (is_digit) begin
            if (oct_mul > {3'b0, OCTET_MAX}) begin
              state_next.octet_acc = OCTET_OVER;
              state_next.ip_valid  = 1'b0;
            end else begin
              state_next.octet_acc = oct_mul[8:0];
            end
          end else if (char_in == CH_DOT) begin
            state_next.octet_acc = 9'd0;
            state_next.dot_count = dot_inc;
            if (dot_inc > IP_DOTS) state_next.ip_valid = 1'b0;
          end else begin
            state_next.ip_valid = 1'b0;
          end
        end
      end
      PH_PORT: begin
        if (char_in == CH_SLASH) begin
          state_next.phase = PH_PATH;
          role             = ROLE_PATH;
        end else if (is_digit) begin
          if (port_mul > {4'b0, PORT_MAX}) begin
            state_next.phase      = PH_DISCARD;
            state_next.error_code = ERR_PORT_OVF;
          end else begin
            state_next.port_acc = port_mul[15:0];
            role                = ROLE_PORT;
          end
        end else begin
          state_next.phase      = PH_DISCARD;
          state_next.error_code = ERR_PORT_CHAR;
        end
      end
      PH_PATH: begin
        if (char_in == CH_QMARK) begin
          state_next.phase = PH_QUERY;
          role             = ROLE_QUERY;
        end else begin
          role = ROLE_PATH;
        end
      end
      PH_QUERY: role = ROLE_QUERY;
      default:  role = ROLE_DISCARD;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/url_stream_parser_top.sv
// URL stream parser top level: input register, scheme hold buffer, tagger, result register.
//
//  channel | beat        | handshake               | direction
//  --------+-------------+-------------------------+----------
//  byte    | in_beat_t   | byte_valid / byte_ready | in
//  tag     | out_beat_t  | tag_valid  / tag_ready  | out
//
// Whitespace and body bytes pass through the input register, then the result register;
// a new byte can enter while the last is still in flight. Bytes that may still form a
// scheme are held without output; the byte that settles the scheme joins them, then the
// m held bytes (m at most 8) leave through the single result register, one per cycle
// while tag_ready allows, and input waits until they are out.
// rst is synchronous and clears all control state; no clearing pass.
// A stalled result register still lets the input register take one beat.
`default_nettype none

module url_stream_parser_top
  import usp_pkg::*;
#(
  parameter int MAX_HOST = 255
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_beat_t  byte_data,
  output logic      tag_valid,
  input  logic      tag_ready,
  output out_beat_t tag_data
);

  localparam int HOST_W = $clog2(MAX_HOST + 1);

  // input register
  logic     iv;
  in_beat_t ib;

  // result register
  logic      ov;
  out_beat_t ob;
  out_beat_t out_next;

  // parse state
  body_state_t        bst;
  body_state_t        bst_next;
  body_state_t        body_next;
  logic [HOST_W-1:0]  host_count;
  logic [HOST_W-1:0]  host_next;
  logic [HOST_W-1:0]  body_host;
  logic [HOST_W+7:0]  host_wide;

  // scheme hold buffer; one extra slot for the deciding byte
  logic [2:0]         prefix_count;
  logic [NUM_SCH-1:0] alive;
  logic [7:0]         held_bytes [8];

  // replay of held bytes
  logic       flush_active;
  logic [2:0] flush_idx;
  logic [2:0] flush_last;
  logic       flush_fixed;   // fixed role, else bytes go through the tagger
  logic [2:0] flush_role;
  logic       flush_eou;

  logic               out_free;
  logic               fl_go;
  logic               in_go;
  logic               in_ws;
  logic               ws_char;
  logic               ws_emit;
  logic               pfx_go;
  logic               body_direct;
  logic               body_use;
  logic               hold;
  logic [2:0]         held;
  logic [NUM_SCH-1:0] alive_in;
  logic [7:0]         cur_char;
  logic [2:0]         body_role;
  scheme_res_t        sres;
  logic               emit;
  logic               emit_last;
  logic [2:0]         emit_role;
  logic               ok;

  assign tag_valid = ov;
  assign tag_data  = ob;

  // handshake and work selection
  always_comb begin
    out_free    = !ov || tag_ready;
    fl_go       = flush_active && out_free;
    in_go       = !flush_active && iv && out_free;
    byte_ready  = !iv || in_go;
    in_ws       = (bst.phase == PH_WS);
    ws_char     = ib.char_in inside {CH_SPACE, CH_TAB};
    ws_emit     = in_go && in_ws && ws_char;
    pfx_go      = in_go && ((in_ws && !ws_char) || (bst.phase == PH_PREFIX));
    body_direct = in_go && !in_ws && (bst.phase != PH_PREFIX);
    body_use    = body_direct || (fl_go && !flush_fixed);
    cur_char    = flush_active ? held_bytes[flush_idx] : ib.char_in;
    held        = in_ws ? 3'd0 : prefix_count;
    alive_in    = in_ws ? '1 : alive;
  end

  usp_scheme u_scheme (
    .held    (held),
    .alive   (alive_in),
    .char_in (ib.char_in),
    .res     (sres)
  );

  usp_body #(
    .MAX_HOST (MAX_HOST)
  ) u_body (
    .char_in    (cur_char),
    .state      (bst),
    .host_count (host_count),
    .state_next (body_next),
    .host_next  (body_host),
    .role       (body_role)
  );

  // next state, result beat
  always_comb begin
    hold      = sres.proper && !ib.end_of_url && (held != HOLD_MAX);
    bst_next  = bst;
    host_next = host_count;
    if (body_use) begin
      bst_next  = body_next;
      host_next = body_host;
    end
    if (pfx_go) begin
      if (sres.full) begin
        if (sres.full_ok) begin
          bst_next.phase = PH_HOST;
        end else begin
          bst_next.phase      = PH_DISCARD;
          bst_next.error_code = ERR_SCHEME;
        end
      end else if (hold) begin
        bst_next.phase = PH_PREFIX;
      end else if (sres.starts_http) begin
        bst_next.phase      = PH_DISCARD;
        bst_next.error_code = ERR_PREFIX;
      end else begin
        bst_next.phase = PH_HOST;   // no scheme: held bytes replay as body
      end
    end

    emit      = ws_emit || body_direct || fl_go;
    emit_last = fl_go ? (flush_eou && (flush_idx == flush_last)) : ib.end_of_url;
    if (ws_emit) begin
      emit_role = ROLE_SKIP;
    end else if (fl_go && flush_fixed) begin
      emit_role = flush_role;
    end else begin
      emit_role = body_role;
    end

    // summary from the state after this byte
    ok        = (bst_next.error_code == ERR_NONE);
    host_wide = {8'b0, host_next};

    out_next.char_out    = cur_char;
    out_next.role        = emit_role;
    out_next.last_of_url = emit_last;
    if (emit_last) begin
      out_next.error        = bst_next.error_code;
      out_next.host_is_ip   = ok && bst_next.ip_valid && (bst_next.dot_count == IP_DOTS);
      out_next.port_number  = ok ? bst_next.port_acc : 16'd0;
      out_next.host_length  = host_wide[7:0];
      out_next.default_path = ok && (bst_next.phase <= PH_PORT);
    end else begin
      out_next.error        = ERR_NONE;
      out_next.host_is_ip   = 1'b0;
      out_next.port_number  = 16'd0;
      out_next.host_length  = 8'd0;
      out_next.default_path = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iv           <= 1'b0;
      ov           <= 1'b0;
      flush_active <= 1'b0;
      bst          <= BODY_RESET;
      host_count   <= '0;
      prefix_count <= 3'd0;
    end else begin
      if (byte_ready) iv <= byte_valid;
      if (out_free) ov <= emit;
      if (emit && emit_last) begin
        // URL done: back to reset state
        bst          <= BODY_RESET;
        host_count   <= '0;
        prefix_count <= 3'd0;
      end else begin
        bst        <= bst_next;
        host_count <= host_next;
        if (pfx_go) prefix_count <= hold ? held + 3'd1 : 3'd0;
      end
      if (pfx_go && !hold) begin
        flush_active <= 1'b1;
      end else if (fl_go && (flush_idx == flush_last)) begin
        flush_active <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (byte_ready) ib <= byte_data;
    if (out_free && emit) ob <= out_next;
    if (pfx_go) begin
      held_bytes[held] <= ib.char_in;
      alive            <= sres.match;
      flush_idx        <= 3'd0;
      flush_last       <= held;
      flush_fixed      <= sres.full || sres.starts_http;
      flush_role       <= (sres.full && sres.full_ok) ? ROLE_SCHEME : ROLE_DISCARD;
      flush_eou        <= ib.end_of_url;
    end else if (fl_go) begin
      flush_idx <= flush_idx + 3'd1;
    end
  end

`ifndef SYNTHESIS
  a_err_clears_summary: assert property (@(posedge clk) disable iff (rst)
    tag_valid && tag_data.last_of_url && (tag_data.error != ERR_NONE)
    |-> (tag_data.port_number == 16'd0) && !tag_data.host_is_ip && !tag_data.default_path)
    else $error("summary fields set on an errored URL");

  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last |=> (bst == BODY_RESET) && (prefix_count == 3'd0) && !flush_active)
    else $error("parse state not restored after last beat");

  a_hold_in_prefix: assert property (@(posedge clk) disable iff (rst)
    (prefix_count != 3'd0) |-> (bst.phase == PH_PREFIX))
    else $error("held bytes outside scheme phase");

  a_flush_bounds: assert property (@(posedge clk) disable iff (rst)
    flush_active |-> (flush_idx <= flush_last))
    else $error("replay index past held bytes");
`endif

endmodule

`default_nettype wire
